// File: rtl/core/rci_pkg.sv
// Package for the ray/circle intersection core: field widths, pipeline
// constants and the side-band record carried alongside the square root.
// No dependencies.
package rci_pkg;

    localparam int IN_W      = 192;  // input tdata, padded to whole bytes
    localparam int OUT_W     = 96;   // output tdata
    localparam int M_W       = 33;   // p - c, exact
    localparam int B_W       = 50;   // b = m.d, Q.30
    localparam int K_W       = 68;   // k = m.m - r*r, Q.32
    localparam int DISC_W    = 100;  // discriminant, Q.60
    localparam int SQRT_BITS = 49;   // root bits, one per pipeline stage
    localparam int T30_W     = 51;
    localparam int T16_W     = 37;
    localparam int OFF_W     = 54;   // t16 * d, Q.30

    // Values that ride along the root pipeline
    typedef struct packed {
        logic signed [B_W-1:0] b;
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [15:0]    dx;
        logic signed [15:0]    dy;
        logic                  miss;
    } t_side;

endpackage

// File: rtl/core/rci_front.sv
// Front end: difference, dot products, squares and discriminant over five
// register stages. Depends on rci_pkg.
module rci_front
    import rci_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [IN_W-1:0]        i_data,
    output logic                   o_vld,
    output logic [DISC_W-1:0]      o_disc,
    output t_side                  o_side
);

    logic signed [31:0] w_px, w_py, w_cx, w_cy;
    logic signed [15:0] w_dx, w_dy;
    logic [30:0]        w_r;

    assign w_px = i_data[31:0];
    assign w_py = i_data[63:32];
    assign w_dx = i_data[79:64];
    assign w_dy = i_data[95:80];
    assign w_cx = i_data[127:96];
    assign w_cy = i_data[159:128];
    assign w_r  = i_data[190:160];

    logic [4:0] r_vld;

    // stage 0: m = p - c
    logic signed [M_W-1:0] r0_mx, r0_my;
    logic signed [31:0]    r0_px, r0_py;
    logic signed [15:0]    r0_dx, r0_dy;
    logic [30:0]           r0_r;

    // stage 1: products
    logic signed [48:0]    r1_bx, r1_by;
    logic signed [65:0]    r1_mxx, r1_myy;
    logic [61:0]           r1_rr;
    logic signed [31:0]    r1_px, r1_py;
    logic signed [15:0]    r1_dx, r1_dy;

    // stage 2: sums
    logic signed [B_W-1:0] r2_b;
    logic signed [K_W-1:0] r2_k;
    logic signed [31:0]    r2_px, r2_py;
    logic signed [15:0]    r2_dx, r2_dy;

    // stage 3: b squared in partial products
    logic [47:0]           r3_hh;
    logic [48:0]           r3_hl;
    logic [49:0]           r3_ll;
    logic signed [K_W-1:0] r3_k;
    logic                  r3_miss;
    logic signed [B_W-1:0] r3_b;
    logic signed [31:0]    r3_px, r3_py;
    logic signed [15:0]    r3_dx, r3_dy;

    // stage 4: discriminant
    logic signed [DISC_W-1:0] r4_disc;
    t_side                    r4_side;

    logic [B_W-1:0]           w_ab;
    logic signed [DISC_W-1:0] n_disc;

    always_comb begin
        w_ab   = r2_b[B_W-1] ? B_W'(-r2_b) : B_W'(r2_b);
        n_disc = $signed(DISC_W'(r3_hh) << 50) + $signed(DISC_W'(r3_hl) << 26)
               + $signed(DISC_W'(r3_ll)) - (DISC_W'(r3_k) <<< 28);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mx  <= M_W'(w_px) - M_W'(w_cx);
            r0_my  <= M_W'(w_py) - M_W'(w_cy);
            r0_px  <= w_px;
            r0_py  <= w_py;
            r0_dx  <= w_dx;
            r0_dy  <= w_dy;
            r0_r   <= w_r;

            r1_bx  <= 49'(r0_mx) * 49'(r0_dx);
            r1_by  <= 49'(r0_my) * 49'(r0_dy);
            r1_mxx <= 66'(r0_mx) * 66'(r0_mx);
            r1_myy <= 66'(r0_my) * 66'(r0_my);
            r1_rr  <= 62'(r0_r) * 62'(r0_r);
            r1_px  <= r0_px;
            r1_py  <= r0_py;
            r1_dx  <= r0_dx;
            r1_dy  <= r0_dy;

            r2_b   <= B_W'(r1_bx) + B_W'(r1_by);
            r2_k   <= K_W'(r1_mxx) + K_W'(r1_myy) - $signed(K_W'(r1_rr));
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;

            r3_hh   <= 48'(w_ab[48:25]) * 48'(w_ab[48:25]);
            r3_hl   <= 49'(w_ab[48:25]) * 49'(w_ab[24:0]);
            r3_ll   <= 50'(w_ab[24:0]) * 50'(w_ab[24:0]);
            r3_k    <= r2_k;
            r3_miss <= (r2_k > 0) && (r2_b > 0);
            r3_b    <= r2_b;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;

            r4_disc      <= n_disc;
            r4_side.b    <= r3_b;
            r4_side.px   <= r3_px;
            r4_side.py   <= r3_py;
            r4_side.dx   <= r3_dx;
            r4_side.dy   <= r3_dy;
            r4_side.miss <= r3_miss || n_disc[DISC_W-1];
        end
    end

    assign o_vld  = r_vld[4];
    assign o_disc = r4_side.miss ? '0 : DISC_W'(r4_disc);
    assign o_side = r4_side;

endmodule

// File: rtl/core/rci_sqrt.sv
// Pipelined floor square root, one root bit per stage with a running
// remainder. Depends on rci_pkg.
module rci_sqrt
    import rci_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [DISC_W-1:0]     i_disc,
    input  t_side                 i_side,
    output logic                  o_vld,
    output logic [SQRT_BITS-1:0]  o_root,
    output t_side                 o_side
);

    logic [SQRT_BITS:0]    r_vld;
    logic [DISC_W-1:0]     r_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0]  r_res  [SQRT_BITS+1];
    t_side                 r_side [SQRT_BITS+1];

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_disc;
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // one stage per root bit, most significant first
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
        localparam int I = SQRT_BITS - 1 - j;
        logic [DISC_W-1:0] w_trial;
        logic              w_take;

        always_comb begin
            w_trial = (DISC_W'(r_res[j]) << (I + 1)) + (DISC_W'(1) << (2 * I));
            w_take  = r_rem[j] >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_take ? r_rem[j] - w_trial : r_rem[j];
                r_res[j+1]  <= w_take ? (r_res[j] | (SQRT_BITS'(1) << I)) : r_res[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_BITS];
    assign o_root = r_res[SQRT_BITS];
    assign o_side = r_side[SQRT_BITS];

endmodule

// File: rtl/core/rci_back.sv
// Back end: distance, hit point offsets, saturation and the output
// register, three stages. Depends on rci_pkg.
module rci_back
    import rci_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [SQRT_BITS-1:0]  i_root,
    input  t_side                 i_side,
    output logic                  o_vld,
    output logic                  o_hit,
    output logic [OUT_W-1:0]      o_data
);

    logic [2:0] r_vld;

    logic signed [T30_W-1:0] w_t30;
    logic [T16_W-1:0]        r1_t16;
    t_side                   r1_side;

    logic signed [OFF_W-1:0] r2_offx, r2_offy;
    logic [T16_W-1:0]        r2_t16;
    t_side                   r2_side;

    logic signed [40:0]      w_qx, w_qy;
    logic [31:0]             w_sx, w_sy, w_t;

    logic                    r3_hit;
    logic [31:0]             r3_t, r3_x, r3_y;

    always_comb begin
        w_t30 = -T30_W'(i_side.b) - $signed(T30_W'(i_root));
        // hit point: floor offset plus origin, saturated
        w_qx  = 41'(r2_side.px) + 41'(r2_offx >>> 14);
        w_qy  = 41'(r2_side.py) + 41'(r2_offy >>> 14);
        if (w_qx > 41'sh7FFFFFFF)       w_sx = 32'h7FFFFFFF;
        else if (w_qx < -41'sh80000000) w_sx = 32'h80000000;
        else                            w_sx = w_qx[31:0];
        if (w_qy > 41'sh7FFFFFFF)       w_sy = 32'h7FFFFFFF;
        else if (w_qy < -41'sh80000000) w_sy = 32'h80000000;
        else                            w_sy = w_qy[31:0];
        w_t   = (|r2_t16[T16_W-1:32]) ? 32'hFFFFFFFF : r2_t16[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // distance, clamped at zero, to Q16.16
            r1_t16  <= w_t30[T30_W-1] ? '0 : T16_W'(w_t30[T30_W-2:14]);
            r1_side <= i_side;

            r2_offx <= $signed(OFF_W'(r1_t16)) * OFF_W'(r1_side.dx);
            r2_offy <= $signed(OFF_W'(r1_t16)) * OFF_W'(r1_side.dy);
            r2_t16  <= r1_t16;
            r2_side <= r1_side;

            r3_hit  <= !r2_side.miss;
            r3_t    <= r2_side.miss ? '0 : w_t;
            r3_x    <= r2_side.miss ? '0 : w_sx;
            r3_y    <= r2_side.miss ? '0 : w_sy;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_hit  = r3_hit;
    assign o_data = {r3_y, r3_x, r3_t};

endmodule

// File: rtl/core/ray_circle_intersection_core.sv
// Ray against circle first-hit core, top level.
// Depends on rci_pkg, rci_front, rci_sqrt and rci_back.
//
// Usage:
//   Slave channel takes one query per transaction: ray origin, direction and
//   circle centre and radius. Master channel returns one result per query:
//   hit flag in tuser, distance and hit point in tdata.
//   An accepted input transaction reaches o_m_tvalid through 5 front stages,
//   50 root stages (entry plus one per root bit) and 3 back stages, the last
//   of which is the output register. Throughput is one transaction per cycle
//   while the receiver does not stall the output; the 49-stage bit-serial
//   square root pipeline sets the latency.
//   All stages share one advance enable: the pipeline moves whenever the
//   output register is empty or being taken. While the receiver holds
//   i_m_tready low with a result pending, o_s_tready is low and every stage
//   holds its contents, so nothing is lost or repeated.
//   Reset clears all valid bits; no results are pending after reset.
//   A miss returns all-zero tdata with tuser low.
module ray_circle_intersection_core
    import rci_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // origin_x[31:0] origin_y[63:32] dir_x[79:64] dir_y[95:80]
    // center_x[127:96] center_y[159:128] radius[190:160], zero pad [191]
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // entry_t[31:0] hit_x[63:32] hit_y[95:64]
    output logic [OUT_W-1:0]  o_m_tdata,
    // hit[0]
    output logic              o_m_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready
);

    logic                  w_en;
    logic                  w_f_vld, w_s_vld;
    logic [DISC_W-1:0]     w_disc;
    t_side                 w_f_side, w_s_side;
    logic [SQRT_BITS-1:0]  w_root;

    // global advance enable
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    rci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_vld   (w_f_vld),
        .o_disc  (w_disc),
        .o_side  (w_f_side)
    );

    rci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_disc  (w_disc),
        .i_side  (w_f_side),
        .o_vld   (w_s_vld),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    rci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .o_vld   (o_m_tvalid),
        .o_hit   (o_m_tuser),
        .o_data  (o_m_tdata)
    );

endmodule

// File: rtl/core/rci_checker.sv
// Port-level checks for the ray/circle intersection core, bound to the top.
// Depends on rci_pkg and ray_circle_intersection_core.
module rci_checker
    import rci_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_s_tready,
    input  logic [OUT_W-1:0]  o_m_tdata,
    input  logic              o_m_tuser,
    input  logic              o_m_tvalid,
    input  logic              i_m_tready
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // a pending stalled result blocks new input transactions
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while output stalled");

    // a miss carries all-zero data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss with nonzero data");

endmodule

bind ray_circle_intersection_core rci_checker u_rci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
